@@ hdl/bdtw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtw_pkg
// Shared constants, types and helpers for the banded DTW engine.
// ----------------------------------------------------------------------------
package bdtw_pkg;

   localparam int MAX_LENGTH = 1024;
   localparam int MAX_BAND   = 128;

   localparam int SAMPLE_W  = 16;
   localparam int COST_W    = 48;
   localparam int BAND_W    = 8;
   localparam int ADDR_W    = $clog2(MAX_LENGTH);
   localparam int CNT_W     = $clog2(MAX_LENGTH + 1);
   localparam int R_W       = $clog2(MAX_BAND + 1);
   localparam int ROW_CELLS = 2 * MAX_BAND + 1;
   localparam int K_W       = $clog2(ROW_CELLS + 1);
   localparam int EXT_W     = CNT_W + R_W;

   localparam logic [COST_W-1:0] INF_COST = {COST_W{1'b1}};

   typedef logic [COST_W-1:0] cost_type;

   typedef struct packed {
      logic              st_we;
      logic [ADDR_W-1:0] st_addr;
      logic [ADDR_W-1:0] q_addr;
      logic [ADDR_W-1:0] c_addr;
      logic [ADDR_W-1:0] b_addr;
      logic              last_load;
      logic              row_bank;
      logic [K_W-1:0]    row_rd_addr;
      logic              row_we;
      logic [K_W-1:0]    row_wr_addr;
      logic              cap_query;
      logic              cap_up;
      logic              up_ok;
      logic              sq_en;
      logic              cell_en;
      logic              first_cell;
      logic              left_ok;
      logic              diag_ok;
      logic              row_init;
      logic              sum_en;
      logic              res_load;
      logic              res_abandon;
   } cmd_type;

   typedef struct packed {
      logic abandon_hit;
   } status_type;

   function automatic cost_type sat_add(input cost_type a, input cost_type b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? INF_COST : s[COST_W-1:0];
   endfunction

   function automatic cost_type min2(input cost_type a, input cost_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

@@ hdl/bdtw_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtw channels
// Valid/ready channel interfaces for sample load, result and band register.
// ----------------------------------------------------------------------------
interface bdtw_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] query_sample;
   logic signed [15:0] candidate_sample;
   logic [47:0]        bound_tail;
   logic [47:0]        abandon_limit;
   logic               last_element;
   modport source (output valid, query_sample, candidate_sample, bound_tail,
                   abandon_limit, last_element, input ready);
   modport sink   (input valid, query_sample, candidate_sample, bound_tail,
                   abandon_limit, last_element, output ready);
endinterface

interface bdtw_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] warp_distance;
   logic        abandoned;
   modport source (output valid, warp_distance, abandoned, input ready);
   modport sink   (input valid, warp_distance, abandoned, output ready);
endinterface

interface bdtw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] warp_band;
   modport source (output valid, warp_band, input ready);
   modport sink   (input valid, warp_band, output ready);
endinterface

@@ hdl/bdtw_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtw_datapath
// Sample stores, rolling row memories, cost arithmetic and result register.
// ----------------------------------------------------------------------------
module bdtw_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  bdtw_pkg::cmd_type                  cmd,
   output bdtw_pkg::status_type               sts,
   input  logic signed [bdtw_pkg::SAMPLE_W-1:0] query_sample,
   input  logic signed [bdtw_pkg::SAMPLE_W-1:0] candidate_sample,
   input  logic [bdtw_pkg::COST_W-1:0]        bound_tail,
   input  logic [bdtw_pkg::COST_W-1:0]        abandon_limit,
   output logic [bdtw_pkg::COST_W-1:0]        warp_distance,
   output logic                               abandoned
);
   import bdtw_pkg::*;

   logic signed [SAMPLE_W-1:0] q_mem [MAX_LENGTH];
   logic signed [SAMPLE_W-1:0] c_mem [MAX_LENGTH];
   cost_type                   b_mem [MAX_LENGTH];
   cost_type                   row0_mem [ROW_CELLS + 1];
   cost_type                   row1_mem [ROW_CELLS + 1];

   logic signed [SAMPLE_W-1:0] q_rd_ff, c_rd_ff, query_ff;
   cost_type                   b_rd_ff, row_rd_ff;
   cost_type                   limit_ff, diag_ff, up_ff, left_ff, row_min_ff, sum_ff;
   logic [SAMPLE_W-1:0]        abs_ff;
   logic [2*SAMPLE_W-1:0]      sq_ff;
   cost_type                   dist_ff;
   logic                       abandoned_ff;

   logic signed [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]          diff_abs;
   cost_type                   local_cost, left_v, diag_v, cell_cost;

   always_ff @(posedge clock) begin
      if (cmd.st_we) begin
         q_mem[cmd.st_addr] <= query_sample;
         c_mem[cmd.st_addr] <= candidate_sample;
         b_mem[cmd.st_addr] <= bound_tail;
      end
      q_rd_ff <= q_mem[cmd.q_addr];
      c_rd_ff <= c_mem[cmd.c_addr];
      b_rd_ff <= b_mem[cmd.b_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.row_we && !cmd.row_bank) begin
         row0_mem[cmd.row_wr_addr] <= cell_cost;
      end
      if (cmd.row_we && cmd.row_bank) begin
         row1_mem[cmd.row_wr_addr] <= cell_cost;
      end
      row_rd_ff <= cmd.row_bank ? row0_mem[cmd.row_rd_addr] : row1_mem[cmd.row_rd_addr];
   end

   always_comb begin
      diff       = {query_ff[SAMPLE_W-1], query_ff} - {c_rd_ff[SAMPLE_W-1], c_rd_ff};
      diff_abs   = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
      local_cost = COST_W'(sq_ff);
      left_v     = cmd.left_ok ? left_ff : INF_COST;
      diag_v     = cmd.diag_ok ? diag_ff : INF_COST;
      cell_cost  = cmd.first_cell ? local_cost
                                  : sat_add(min2(min2(up_ff, left_v), diag_v), local_cost);
   end

   always_ff @(posedge clock) begin
      if (cmd.last_load) begin
         limit_ff <= abandon_limit;
      end
      if (cmd.cap_query) begin
         query_ff <= q_rd_ff;
         diag_ff  <= row_rd_ff;
      end
      if (cmd.row_init) begin
         row_min_ff <= INF_COST;
      end
      if (cmd.cap_up) begin
         up_ff  <= cmd.up_ok ? row_rd_ff : INF_COST;
         abs_ff <= diff_abs[SAMPLE_W-1:0];
      end
      if (cmd.sq_en) begin
         sq_ff <= abs_ff * abs_ff;
      end
      if (cmd.cell_en) begin
         left_ff    <= cell_cost;
         diag_ff    <= up_ff;
         row_min_ff <= min2(row_min_ff, cell_cost);
      end
      if (cmd.sum_en) begin
         sum_ff <= sat_add(row_min_ff, b_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff      <= '0;
         abandoned_ff <= 1'b0;
      end else if (cmd.res_load) begin
         dist_ff      <= cmd.res_abandon ? sum_ff : left_ff;
         abandoned_ff <= cmd.res_abandon;
      end
   end

   assign sts.abandon_hit = (limit_ff != INF_COST) && (sum_ff >= limit_ff);
   assign warp_distance   = dist_ff;
   assign abandoned       = abandoned_ff;

endmodule

@@ hdl/bdtw_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtw_controller
// Load sequencing, band register and row/cell walk of the DTW matrix.
// ----------------------------------------------------------------------------
module bdtw_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_last,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        csr_valid,
   input  logic [bdtw_pkg::BAND_W-1:0] csr_data,
   output logic                        csr_ready,
   input  bdtw_pkg::status_type        sts,
   output bdtw_pkg::cmd_type           cmd
);
   import bdtw_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ROW0 = 4'd1;
   localparam logic [3:0] S_ROW1 = 4'd2;
   localparam logic [3:0] S_CA   = 4'd3;
   localparam logic [3:0] S_CB   = 4'd4;
   localparam logic [3:0] S_CC   = 4'd5;
   localparam logic [3:0] S_CD   = 4'd6;
   localparam logic [3:0] S_RE0  = 4'd7;
   localparam logic [3:0] S_RE1  = 4'd8;
   localparam logic [3:0] S_RE2  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [BAND_W-1:0] band_ff;
   logic [CNT_W-1:0]  loaded_ff, loaded_in, m_ff, m_in;
   logic [R_W-1:0]    r_ff, r_in;
   logic [ADDR_W-1:0] i_ff, i_in, j_ff, j_in, jlo_ff, jlo_in, jhi_ff, jhi_in;
   logic              bank_ff, bank_in, abandon_ff, abandon_in, rsp_valid_ff, rsp_valid_in;

   logic [EXT_W-1:0]  i_x, r_x, m_x, jlo_x, jhi_x, k0_x, k_x, nb_x;
   logic              accept, more_bound, last_row;
   logic [ADDR_W-1:0] pos;

   always_comb begin
      i_x   = EXT_W'(i_ff);
      r_x   = EXT_W'(r_ff);
      m_x   = EXT_W'(m_ff);
      jlo_x = (i_x > r_x) ? i_x - r_x : '0;
      jhi_x = (i_x + r_x < m_x - 1'b1) ? i_x + r_x : m_x - 1'b1;
      k0_x  = jlo_x + r_x - i_x;
      k_x   = EXT_W'(j_ff) + r_x - i_x;
      nb_x  = i_x + r_x + 1'b1;
      more_bound = nb_x < m_x;
      last_row   = (i_x + 1'b1) == m_x;
      pos    = (loaded_ff < CNT_W'(MAX_LENGTH)) ? loaded_ff[ADDR_W-1:0]
                                                : ADDR_W'(MAX_LENGTH - 1);
      accept = req_valid && (state_ff == S_IDLE);
   end

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jlo_in       = jlo_ff;
      jhi_in       = jhi_ff;
      bank_in      = bank_ff;
      abandon_in   = abandon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd             = '0;
      cmd.st_addr     = pos;
      cmd.q_addr      = i_ff;
      cmd.c_addr      = j_ff;
      cmd.b_addr      = nb_x[ADDR_W-1:0];
      cmd.row_bank    = bank_ff;
      cmd.row_rd_addr = K_W'(k_x + 1'b1);
      cmd.row_wr_addr = k_x[K_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.st_we = 1'b1;
               loaded_in = (loaded_ff < CNT_W'(MAX_LENGTH)) ? loaded_ff + 1'b1 : loaded_ff;
               if (req_last) begin
                  cmd.last_load = 1'b1;
                  m_in       = loaded_in;
                  loaded_in  = '0;
                  r_in       = (EXT_W'(band_ff) > EXT_W'(MAX_BAND)) ? R_W'(MAX_BAND)
                                                                  : R_W'(band_ff);
                  i_in       = '0;
                  bank_in    = 1'b0;
                  abandon_in = 1'b0;
                  state_in   = S_ROW0;
               end
            end
         end
         S_ROW0: begin
            cmd.row_rd_addr = k0_x[K_W-1:0];
            jlo_in   = jlo_x[ADDR_W-1:0];
            jhi_in   = jhi_x[ADDR_W-1:0];
            j_in     = jlo_x[ADDR_W-1:0];
            state_in = S_ROW1;
         end
         S_ROW1: begin
            cmd.cap_query = 1'b1;
            cmd.row_init  = 1'b1;
            state_in      = S_CA;
         end
         S_CA: begin
            state_in = S_CB;
         end
         S_CB: begin
            cmd.cap_up = 1'b1;
            cmd.up_ok  = (i_ff != '0) && ((k_x + 1'b1) <= (r_x << 1));
            state_in   = S_CC;
         end
         S_CC: begin
            cmd.sq_en = 1'b1;
            state_in  = S_CD;
         end
         S_CD: begin
            cmd.cell_en    = 1'b1;
            cmd.row_we     = 1'b1;
            cmd.first_cell = (i_ff == '0) && (j_ff == '0);
            cmd.left_ok    = (j_ff != jlo_ff);
            cmd.diag_ok    = (i_ff != '0) && (j_ff != '0);
            if (j_ff == jhi_ff) begin
               state_in = S_RE0;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_CA;
            end
         end
         S_RE0: begin
            if (more_bound) begin
               state_in = S_RE1;
            end else if (last_row) begin
               state_in = S_OUT;
            end else begin
               i_in     = i_ff + 1'b1;
               bank_in  = !bank_ff;
               state_in = S_ROW0;
            end
         end
         S_RE1: begin
            cmd.sum_en = 1'b1;
            state_in   = S_RE2;
         end
         S_RE2: begin
            if (sts.abandon_hit) begin
               abandon_in = 1'b1;
               state_in   = S_OUT;
            end else if (last_row) begin
               state_in = S_OUT;
            end else begin
               i_in     = i_ff + 1'b1;
               bank_in  = !bank_ff;
               state_in = S_ROW0;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load    = 1'b1;
               cmd.res_abandon = abandon_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         band_ff      <= '0;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         m_ff         <= '0;
         r_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         jlo_ff       <= '0;
         jhi_ff       <= '0;
         bank_ff      <= 1'b0;
         abandon_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
         m_ff         <= m_in;
         r_ff         <= r_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         jlo_ff       <= jlo_in;
         jhi_ff       <= jhi_in;
         bank_ff      <= bank_in;
         abandon_ff   <= abandon_in;
         if (csr_valid) begin
            band_ff <= csr_data;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

@@ hdl/banded_dtw_early_abandon.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_dtw_early_abandon
// Sakoe-Chiba banded DTW with per-row early abandoning on a lower bound.
// ----------------------------------------------------------------------------
// Each non-final element is stored as it is taken. The element flagged last
// starts the computation, during which no element is taken. Each row sets
// up its band bounds, then walks its cells, at most 2r+1 of them (the band
// width clipped to the matrix), each through the read, difference, square
// and min/add steps on the row memories, then checks the lower bound if one
// is due. The result is registered once the output register is free. Band
// values above 128 act as 128.
module banded_dtw_early_abandon (
   input logic        clock,
   input logic        reset,
   bdtw_req_if.sink   req_bus,
   bdtw_rsp_if.source rsp_bus,
   bdtw_csr_if.sink   csr_bus
);
   import bdtw_pkg::*;

   cmd_type    cmd;
   status_type sts;

   bdtw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_element),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_data  (csr_bus.warp_band),
      .csr_ready (csr_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdtw_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .query_sample     (req_bus.query_sample),
      .candidate_sample (req_bus.candidate_sample),
      .bound_tail       (req_bus.bound_tail),
      .abandon_limit    (req_bus.abandon_limit),
      .warp_distance    (rsp_bus.warp_distance),
      .abandoned        (rsp_bus.abandoned)
   );

   a_busy_no_load: assert property (@(posedge clock) disable iff (reset)
      cmd.cell_en |-> !req_bus.ready)
      else $error("element taken during computation");

   a_row_index: assert property (@(posedge clock) disable iff (reset)
      cmd.cell_en |-> (cmd.row_wr_addr <= K_W'(2 * MAX_BAND)))
      else $error("row index outside band");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> rsp_bus.valid)
      else $error("result loaded but not shown");

endmodule

@@ dv/banded_dtw_early_abandon_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_dtw_early_abandon_tb
// Self-checking bench for the banded DTW engine: loads directed and random
// series over the request channel, predicts each result in a local DTW
// model, and compares every response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module banded_dtw_early_abandon_tb;
   import bdtw_pkg::*;

   typedef struct packed {
      logic [47:0] distance;
      logic        abandoned;
   } dtw_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdtw_req_if req_bus ();
   bdtw_rsp_if rsp_bus ();
   bdtw_csr_if csr_bus ();

   banded_dtw_early_abandon u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   always #10 clock = ~clock;

   // prediction state
   logic signed [15:0] q_mem [MAX_LENGTH];
   logic signed [15:0] c_mem [MAX_LENGTH];
   logic [47:0]        b_mem [MAX_LENGTH];
   int                 load_cnt = 0;
   logic [7:0]         band_reg = 8'd0;
   dtw_result_type     expected_q[$];

   int  mismatches = 0;
   int  hold_cycles = 0;
   bit  rsp_random = 1'b1;

   function automatic logic [47:0] sq_cost(logic signed [15:0] a, logic signed [15:0] b);
      logic signed [17:0] d;
      logic [16:0]        u;
      d = a - b;
      u = d < 0 ? -d : d;
      return {31'd0, u} * {31'd0, u};
   endfunction

   function automatic dtw_result_type dtw_compute(int m, logic [47:0] limit);
      logic [47:0] cur [ROW_CELLS];
      logic [47:0] prv [ROW_CELLS];
      dtw_result_type res;
      int r, jlo, jhi, k;
      logic [47:0] row_min, loc, cell_cost, lf, up, dg, s;
      r = band_reg > MAX_BAND ? MAX_BAND : band_reg;
      for (int n = 0; n < ROW_CELLS; n++) begin
         cur[n] = INF_COST;
         prv[n] = INF_COST;
      end
      for (int i = 0; i < m; i++) begin
         jlo = i > r ? i - r : 0;
         jhi = (i + r < m - 1) ? i + r : m - 1;
         row_min = INF_COST;
         for (int j = jlo; j <= jhi; j++) begin
            k = j + r - i;
            loc = sq_cost(q_mem[i], c_mem[j]);
            if (i == 0 && j == 0) begin
               cell_cost = loc;
            end else begin
               lf = j > jlo ? cur[k-1] : INF_COST;
               up = (i > 0 && k + 1 <= 2 * r) ? prv[k+1] : INF_COST;
               dg = (i > 0 && j > 0) ? prv[k] : INF_COST;
               lf = lf < up ? lf : up;
               lf = lf < dg ? lf : dg;
               s = lf + loc;
               cell_cost = ({1'b0, lf} + {1'b0, loc}) > {1'b0, INF_COST} ? INF_COST : s;
            end
            cur[k] = cell_cost;
            if (cell_cost < row_min) row_min = cell_cost;
         end
         if (i + r + 1 < m) begin
            s = ({1'b0, row_min} + {1'b0, b_mem[i+r+1]}) > {1'b0, INF_COST}
                ? INF_COST : row_min + b_mem[i+r+1];
            if (limit != INF_COST && s >= limit) begin
               res.distance = s;
               res.abandoned = 1'b1;
               return res;
            end
         end
         prv = cur;
      end
      res.distance = prv[r];
      res.abandoned = 1'b0;
      return res;
   endfunction

   task automatic predict_load(logic signed [15:0] q, logic signed [15:0] c,
                               logic [47:0] b, logic [47:0] lim, logic last);
      int pos;
      pos = load_cnt < MAX_LENGTH ? load_cnt : MAX_LENGTH - 1;
      q_mem[pos] = q;
      c_mem[pos] = c;
      b_mem[pos] = b;
      if (load_cnt < MAX_LENGTH) load_cnt++;
      if (last) begin
         expected_q.push_back(dtw_compute(load_cnt, lim));
         load_cnt = 0;
      end
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_sample(logic signed [15:0] q, logic signed [15:0] c,
                              logic [47:0] b, logic [47:0] lim, logic last, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.query_sample     <= q;
      req_bus.candidate_sample <= c;
      req_bus.bound_tail       <= b;
      req_bus.abandon_limit    <= lim;
      req_bus.last_element     <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_load(q, c, b, lim, last);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_band(logic [7:0] v);
      drain();
      csr_bus.valid     <= 1'b1;
      csr_bus.warp_band <= v;
      do @(posedge clock); while (!csr_bus.ready);
      band_reg = v;
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] rnd_sample();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 16'sh7fff;
      if (p == 1) return 16'sh8000;
      return 16'($urandom());
   endfunction

   function automatic logic [47:0] rnd_cost(int scale);
      logic [47:0] v;
      v = 48'({$urandom(), $urandom()});
      case ($urandom_range(0, 3))
         0: return v;
         1: return v >> scale;
         2: return 48'd0;
         default: return v >> (scale + 8);
      endcase
   endfunction

   task automatic send_series(int len, logic [47:0] lim, bit gaps);
      for (int n = 0; n < len; n++)
         send_sample(rnd_sample(), rnd_sample(), rnd_cost(16), lim, n == len - 1, gaps);
   endtask

   task automatic test_directed();
      write_band(8'd0);
      send_sample(16'sh7fff, 16'sh8000, 48'd0, INF_COST, 1'b1, 1'b0);
      send_sample(16'sh8000, 16'sh8000, INF_COST, 48'd0, 1'b0, 1'b0);
      send_sample(16'sh7fff, 16'sh0000, INF_COST, INF_COST, 1'b1, 1'b0);
      write_band(8'd1);
      send_sample(16'sh0100, 16'sh0000, 48'd5, INF_COST, 1'b0, 1'b0);
      send_sample(16'sh0000, 16'sh0100, 48'd5, INF_COST, 1'b0, 1'b0);
      send_sample(16'sh0200, 16'sh0200, 48'd0, 48'd1, 1'b1, 1'b0);
      send_sample(16'sh7fff, 16'sh8000, INF_COST, 48'd1, 1'b0, 1'b0);
      send_sample(16'sh8000, 16'sh7fff, INF_COST, 48'd1, 1'b0, 1'b0);
      send_sample(16'sh0000, 16'sh0000, INF_COST, 48'd1, 1'b0, 1'b0);
      send_sample(16'sh0000, 16'sh0000, INF_COST, INF_COST - 1, 1'b1, 1'b0);
      write_band(8'd255);
      send_series(6, INF_COST, 1'b0);
      write_band(8'd128);
      send_series(5, 48'd1000, 1'b0);
   endtask

   task automatic test_overlong();
      write_band(8'd2);
      send_series(MAX_LENGTH + 3, INF_COST, 1'b0);
   endtask

   task automatic test_random(int budget);
      int sent, len;
      logic [47:0] lim;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 29) == 0)
            write_band($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 6)));
         len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8);
         case ($urandom_range(0, 3))
            0: lim = INF_COST;
            1: lim = 48'({$urandom(), $urandom()} >> $urandom_range(14, 30));
            2: lim = 48'({$urandom(), $urandom()});
            default: lim = 48'($urandom_range(0, 3));
         endcase
         send_series(len, lim, 1'b1);
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      write_band(8'd1);
      hold_cycles = 3000;
      for (int n = 0; n < 8; n++) send_series(2, INF_COST, 1'b0);
      drain();
      send_series(3, INF_COST, 1'b0);
   endtask

   // response side
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_random) begin
            rsp_bus.ready <= gap_len() == 0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dtw_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_bus.warp_distance);
         end else begin
            exp_r = expected_q.pop_front();
            if (exp_r.distance !== rsp_bus.warp_distance ||
                exp_r.abandoned !== rsp_bus.abandoned) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%b actual %h/%b", exp_r.distance,
                           exp_r.abandoned, rsp_bus.warp_distance, rsp_bus.abandoned);
            end
         end
      end
   end

   initial begin
      req_bus.valid            <= 1'b0;
      req_bus.query_sample     <= '0;
      req_bus.candidate_sample <= '0;
      req_bus.bound_tail       <= '0;
      req_bus.abandon_limit    <= '0;
      req_bus.last_element     <= 1'b0;
      csr_bus.valid            <= 1'b0;
      csr_bus.warp_band        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overlong();
      test_backpressure();
      test_random(400);
      drain();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("simulation failed");
      $finish;
   end

endmodule
